>>> sv/mhd_pkg.sv
// shared types, widths and the arctangent table for the magnetometer heading core
// depends on nothing; imported by every module of the core
package mhd_pkg;

  // defaults for top-level parameters and the length of the arctangent table
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;
  localparam int unsigned TABLE_LEN        = 24;

  // field and datapath widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned AXIS_W      = 16;
  localparam int unsigned HEAD_W      = 9;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned PRE_SHIFT   = 8;   // magnitude scaling before the rotations
  localparam int unsigned XY_W        = 27;  // holds |v| * 256 * cordic gain with margin
  localparam int unsigned Z_W         = 25;  // signed angle, 1/65536 degree units
  localparam int unsigned MAG_W       = 24;  // unsigned angle up to 180 degrees
  localparam int unsigned FRAC_W      = 16;  // fraction bits of the angle
  localparam int unsigned ATAN_W      = 22;

  localparam logic [MAG_W-1:0] DEG45_Q16  = MAG_W'(45 * 65536);
  localparam logic [MAG_W-1:0] DEG90_Q16  = MAG_W'(90 * 65536);
  localparam logic [MAG_W-1:0] DEG180_Q16 = MAG_W'(180 * 65536);

  // how the first-quadrant angle is obtained
  typedef enum logic [2:0] {
    KIND_CORDIC,  // general position, rotations decide
    KIND_ABSENT,  // x and y both zero
    KIND_ON_X,    // |y| zero, angle 0
    KIND_ON_Y,    // |x| zero, angle 90
    KIND_DIAG     // |x| equals |y|, angle 45
  } mhd_kind_e;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x_field;
    logic signed [AXIS_W-1:0] y_field;
    logic signed [AXIS_W-1:0] z_field;
    logic [AXIS_W-1:0]        ax;
    logic [AXIS_W-1:0]        ay;
    mhd_kind_e                kind;
  } mhd_item_t;

  typedef struct packed {
    mhd_item_t              item;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } mhd_work_t;

  // round(atan(2^-i) * 180/pi * 65536)
  function automatic logic [ATAN_W-1:0] atan_q16(input int unsigned i);
    logic [ATAN_W-1:0] r;
    case (i)
      0:       r = ATAN_W'(2949120);
      1:       r = ATAN_W'(1740967);
      2:       r = ATAN_W'(919879);
      3:       r = ATAN_W'(466945);
      4:       r = ATAN_W'(234379);
      5:       r = ATAN_W'(117304);
      6:       r = ATAN_W'(58666);
      7:       r = ATAN_W'(29335);
      8:       r = ATAN_W'(14668);
      9:       r = ATAN_W'(7334);
      10:      r = ATAN_W'(3667);
      11:      r = ATAN_W'(1833);
      12:      r = ATAN_W'(917);
      13:      r = ATAN_W'(458);
      14:      r = ATAN_W'(229);
      15:      r = ATAN_W'(115);
      16:      r = ATAN_W'(57);
      17:      r = ATAN_W'(29);
      18:      r = ATAN_W'(14);
      19:      r = ATAN_W'(7);
      20:      r = ATAN_W'(4);
      21:      r = ATAN_W'(2);
      22:      r = ATAN_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/magnetometer_heading_atan2_core.sv
// top level of the magnetometer heading core: byte burst in, axes and heading out
// depends on mhd_pkg, mhd_front, mhd_queue and mhd_back
//
// channel   dir  tdata                                          tuser
// s_axis    in   [7:0] x_high_byte .. [47:40] y_low_byte        -
// m_axis    out  [15:0] x_field [31:16] y_field [47:32] z_field heading_absent
//                [56:48] heading_deg, upper bits zero
//
// one burst accepted per cycle, sustained while m_axis_tready stays high; each burst gives one result
// the path from accept to m_axis_tvalid runs through the front register,
// the queue, one registered rotation per step and the output register
// the rotation pipeline sets the latency; the queue lets the front keep
// taking bursts, until the queue is full, while m_axis_tready stalls the back end
// rst_ni clears all valid flags and queue pointers; data registers are not reset
module magnetometer_heading_atan2_core #(
  parameter int unsigned CORDIC_STEPS = mhd_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned QUEUE_DEPTH  = mhd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // x_high_byte, x_low_byte, z_high_byte, z_low_byte, y_high_byte, y_low_byte
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mhd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // x_field, y_field, z_field, heading_deg, zero fill
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mhd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // heading_absent
  output logic                            m_axis_tuser
);
  import mhd_pkg::*;

  // front end to queue
  logic      front_valid, front_ready;
  mhd_item_t front_item;
  // queue to back end
  logic      queue_valid, queue_ready;
  mhd_item_t queue_item;

  // packing, quadrant fold and special-case classification
  mhd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_item_o  (front_item)
  );

  // decouples the two halves so each can stall on its own
  mhd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_item_o   (queue_item)
  );

  // rotations, unfold to -180..180 and the output register
  mhd_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (queue_valid),
    .in_ready_o   (queue_ready),
    .in_item_i    (queue_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_absent_o (m_axis_tuser)
  );

endmodule

>>> sv/mhd_front.sv
// front end: packs the register bytes, folds to the first quadrant and classifies
// depends on mhd_pkg
module mhd_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mhd_pkg::IN_TDATA_W-1:0]   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mhd_pkg::mhd_item_t               out_item_o
);
  import mhd_pkg::*;

  logic signed [AXIS_W-1:0] x_s, y_s, z_s;
  logic [AXIS_W:0]          x_neg, y_neg;
  logic [AXIS_W-1:0]        ax, ay;
  mhd_item_t                item_d, item_q;
  logic                     valid_q;

  // tdata bytes: x high, x low, z high, z low, y high, y low
  assign x_s = {in_data_i[7:0],   in_data_i[15:8]};
  assign z_s = {in_data_i[23:16], in_data_i[31:24]};
  assign y_s = {in_data_i[39:32], in_data_i[47:40]};

  // 17-bit negation so that -32768 folds to 32768
  assign x_neg = -{x_s[AXIS_W-1], x_s};
  assign y_neg = -{y_s[AXIS_W-1], y_s};
  assign ax = x_s[AXIS_W-1] ? x_neg[AXIS_W-1:0] : x_s;
  assign ay = y_s[AXIS_W-1] ? y_neg[AXIS_W-1:0] : y_s;

  always_comb begin
    item_d.x_field = x_s;
    item_d.y_field = y_s;
    item_d.z_field = z_s;
    item_d.ax      = ax;
    item_d.ay      = ay;
    if (ax == '0 && ay == '0) begin
      item_d.kind = KIND_ABSENT;
    end else if (ay == '0) begin
      item_d.kind = KIND_ON_X;
    end else if (ax == '0) begin
      item_d.kind = KIND_ON_Y;
    end else if (ax == ay) begin
      item_d.kind = KIND_DIAG;
    end else begin
      item_d.kind = KIND_CORDIC;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

>>> sv/mhd_queue.sv
// short fifo of classified items between front end and rotation pipeline
// depends on mhd_pkg
module mhd_queue #(
  parameter int unsigned DEPTH = mhd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  mhd_pkg::mhd_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output mhd_pkg::mhd_item_t pop_item_o
);
  import mhd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mhd_item_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> sv/mhd_cordic_stage.sv
// one registered vectoring rotation with a fixed shift
// depends on mhd_pkg
module mhd_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mhd_pkg::mhd_work_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mhd_pkg::mhd_work_t out_data_o
);
  import mhd_pkg::*;

  localparam logic signed [Z_W-1:0] ANGLE = $signed(Z_W'(atan_q16(STEP)));

  logic signed [XY_W-1:0] dx, dy;
  mhd_work_t              work_d, work_q;
  logic                   valid_q;

  // arithmetic shift rounds toward minus infinity
  assign dx = in_data_i.y >>> STEP;
  assign dy = in_data_i.x >>> STEP;

  always_comb begin
    work_d.item = in_data_i.item;
    if (!in_data_i.y[XY_W-1]) begin
      work_d.x = in_data_i.x + dx;
      work_d.y = in_data_i.y - dy;
      work_d.z = in_data_i.z + ANGLE;
    end else begin
      work_d.x = in_data_i.x - dx;
      work_d.y = in_data_i.y + dy;
      work_d.z = in_data_i.z - ANGLE;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      work_q <= work_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = work_q;

endmodule

>>> sv/mhd_back.sv
// back end: rotation pipeline, quadrant unfold and output register
// depends on mhd_pkg and mhd_cordic_stage
module mhd_back #(
  parameter int unsigned CORDIC_STEPS = mhd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  mhd_pkg::mhd_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mhd_pkg::OUT_TDATA_W-1:0] out_data_o,
  output logic                            out_absent_o
);
  import mhd_pkg::*;

  localparam int unsigned STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  logic [STEPS:0] stg_valid, stg_ready;
  mhd_work_t      stg_data [STEPS+1];

  // load the scaled magnitudes
  assign stg_valid[0]   = in_valid_i;
  assign in_ready_o     = stg_ready[0];
  assign stg_data[0].item = in_item_i;
  assign stg_data[0].x  = $signed(XY_W'({in_item_i.ax, PRE_SHIFT'(0)}));
  assign stg_data[0].y  = $signed(XY_W'({in_item_i.ay, PRE_SHIFT'(0)}));
  assign stg_data[0].z  = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    mhd_cordic_stage #(
      .STEP (k)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[k]),
      .in_ready_o  (stg_ready[k]),
      .in_data_i   (stg_data[k]),
      .out_valid_o (stg_valid[k+1]),
      .out_ready_i (stg_ready[k+1]),
      .out_data_o  (stg_data[k+1])
    );
  end

  // clamp, pick special angles, unfold to the full circle
  mhd_work_t               last;
  logic [MAG_W-1:0]        z_clamp, mag, mag_full;
  logic [HEAD_W-1:0]       deg_u, deg;
  logic [OUT_TDATA_W-1:0]  data_d, data_q;
  logic                    absent_d, absent_q, valid_q;

  assign last = stg_data[STEPS];

  always_comb begin
    if (last.z[Z_W-1]) begin
      z_clamp = '0;
    end else if (last.z > $signed(Z_W'(DEG90_Q16))) begin
      z_clamp = DEG90_Q16;
    end else begin
      z_clamp = last.z[MAG_W-1:0];
    end
    case (last.item.kind)
      KIND_CORDIC: mag = z_clamp;
      KIND_ON_Y:   mag = DEG90_Q16;
      KIND_DIAG:   mag = DEG45_Q16;
      default:     mag = '0;
    endcase
    mag_full = last.item.x_field[AXIS_W-1] ? DEG180_Q16 - mag : mag;
    deg_u    = {1'b0, mag_full[MAG_W-1:FRAC_W]};
    absent_d = last.item.kind == KIND_ABSENT;
    if (absent_d) begin
      deg = '0;
    end else if (last.item.y_field[AXIS_W-1]) begin
      deg = -deg_u;
    end else begin
      deg = deg_u;
    end
    data_d = OUT_TDATA_W'({deg, last.item.z_field, last.item.y_field, last.item.x_field});
  end

  assign stg_ready[STEPS] = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (stg_ready[STEPS]) begin
      valid_q <= stg_valid[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_valid[STEPS] && stg_ready[STEPS]) begin
      data_q   <= data_d;
      absent_q <= absent_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_data_o   = data_q;
  assign out_absent_o = absent_q;

endmodule
